>>> rtl/core/dchq_pkg.sv
// shared types, widths and codes of the dynamic convex hull max query block
package dchq_pkg;

    localparam int DEF_CAPACITY = 1024;

    localparam int FUNC_W   = 1;
    localparam int SLOPE_W  = 32;
    localparam int ICPT_W   = 48;
    localparam int POINT_W  = 32;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int LINE_W   = SLOPE_W + ICPT_W;

    // redundancy test arithmetic
    localparam int DB_W     = ICPT_W + 1;       // intercept difference
    localparam int DM_W     = SLOPE_W + 1;      // slope difference
    localparam int MUL_W    = 33;               // shared signed multiplier operand
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DLO_W    = 24;               // low part of an intercept difference
    localparam int ACC_W    = DB_W + DM_W + 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] m;
        logic signed [ICPT_W-1:0]  b;
    } t_line;

endpackage

>>> rtl/core/dchq_if.sv
// request and response channel interfaces of the hull block
interface dchq_req_if import dchq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [SLOPE_W-1:0]  slope;
    logic signed [ICPT_W-1:0]   intercept;
    logic signed [POINT_W-1:0]  point;

    modport source (output valid, func, slope, intercept, point, input ready);
    modport sink   (input valid, func, slope, intercept, point, output ready);
endinterface

interface dchq_rsp_if import dchq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

>>> rtl/core/dchq_ram.sv
// generic single write port, single read port ram with registered read
module dchq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/dynamic_convex_hull_max_query_top.sv
// upper envelope line store with exact redundancy test and maximum queries
//
// i_req carries one item per transfer: func 0 inserts line slope*x+intercept,
// func 1 asks for the maximum of the stored lines at point. o_rsp returns one
// transfer per item: value (zero for inserts) and status (ok, empty hull,
// store full). Lines sit in one ram sorted by slope; the single read port and
// the shared 33x33 multiplier set the timing.
// query: a binary search over the n stored lines, with two reads and
// two products per search step.
// insert: a binary search for the slope, a neighbor test (one read plus
// a two-product compare) for each neighbor, then a move for each stored
// line that moves; a removed line costs a test instead of a move.
// an item is taken only while no other is in flight; a finished response
// waits in the output register, and a new item can be taken meanwhile.
// if o_rsp stalls, the next finished response holds until the register frees.
// synchronous reset empties the hull at once; ram contents are not cleared,
// only the first count entries are ever read.
module dynamic_convex_hull_max_query_top import dchq_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dchq_req_if.sink    i_req,
    dchq_rsp_if.source  o_rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_ISRCH, S_ISRCH_W, S_NB_P, S_NB_PW, S_NB_N, S_NB_NW, S_TNEW,
        S_TEST, S_RGT, S_RGT_W, S_LFT, S_LFT_W, S_CSET, S_CPY_RD, S_CPY_WR,
        S_WNEW, S_QSRCH, S_QRD0, S_QRD1, S_QM2, S_QF1, S_QF2, S_DONE
    } t_state;

    typedef enum logic [1:0] {T_NEW, T_RGT, T_LFT} t_tsel;

    t_state                    r_state;
    t_tsel                     r_tsel;
    logic [CW-1:0]             r_cnt, r_lo, r_hi, r_mid, r_l, r_r, r_k, r_gap;
    logic                      r_up;
    t_line                     r_new, r_p1, r_p2, r_n1, r_n2;
    logic signed [POINT_W-1:0] r_x;
    logic [DB_W-1:0]           r_d1, r_d2;
    logic [DM_W-1:0]           r_e1, r_e2;
    logic [ACC_W-1:0]          r_acc;
    logic [2:0]                r_step;
    logic signed [PROD_W-1:0]  r_prod;
    logic [VALUE_W-1:0]        r_v0, r_val;
    logic signed [ICPT_W-1:0]  r_vb;
    logic [STATUS_W-1:0]       r_stat;
    logic                      r_ovalid;
    logic [VALUE_W-1:0]        r_ovalue;
    logic [STATUS_W-1:0]       r_ostatus;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [LINE_W-1:0] ram_wdata, ram_rdata;
    t_line             ram_line;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    t_line                   tx, ty, tz;
    logic [DB_W-1:0]         t_d1, t_d2;
    logic [DM_W-1:0]         t_e1, t_e2;
    logic [ACC_W-1:0]        prod_ext, prod_shl, acc_sum;
    logic                    red;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid;
    logic [VALUE_W-1:0]      qval;
    logic [CW:0]             new_cnt;

    dchq_ram #(.WIDTH(LINE_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_line = ram_rdata;
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CW:1];
    assign qval     = r_prod[VALUE_W-1:0] + {{(VALUE_W-ICPT_W){r_vb[ICPT_W-1]}}, r_vb};
    assign new_cnt  = {1'b0, r_l} + {{CW{1'b0}}, 1'b1} + {1'b0, r_cnt} - {1'b0, r_r};

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.value  = r_ovalue;
    assign o_rsp.status = r_ostatus;

    // operand lines of the three-line test: x left, y middle, z right
    always_comb begin
        case (r_state)
            S_RGT_W: begin
                tx = r_new; ty = r_n1; tz = ram_line;
            end
            S_LFT_W: begin
                tx = ram_line; ty = r_p1; tz = r_new;
            end
            default: begin
                tx = r_p1; ty = r_new; tz = r_n1;
            end
        endcase
        t_d1 = {tx.b[ICPT_W-1], tx.b} - {ty.b[ICPT_W-1], ty.b};
        t_e1 = {tz.m[SLOPE_W-1], tz.m} - {ty.m[SLOPE_W-1], ty.m};
        t_d2 = {ty.b[ICPT_W-1], ty.b} - {tz.b[ICPT_W-1], tz.b};
        t_e2 = {ty.m[SLOPE_W-1], ty.m} - {tx.m[SLOPE_W-1], tx.m};
    end

    // accumulate d1*e1 - d2*e2 from four partial products
    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        prod_shl = prod_ext << DLO_W;
        case (r_step)
            3'd1:    acc_sum = r_acc + prod_shl;
            3'd2:    acc_sum = r_acc + prod_ext;
            3'd3:    acc_sum = r_acc - prod_shl;
            3'd4:    acc_sum = r_acc - prod_ext;
            default: acc_sum = r_acc;
        endcase
        red = !acc_sum[ACC_W-1];
    end

    // shared multiplier operands, ram read address and ram write port
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        case (r_state)
            S_TEST: begin
                case (r_step)
                    3'd0: begin
                        mul_a = {{(MUL_W-DB_W+DLO_W){r_d1[DB_W-1]}}, r_d1[DB_W-1:DLO_W]};
                        mul_b = {{(MUL_W-DM_W){r_e1[DM_W-1]}}, r_e1};
                    end
                    3'd1: begin
                        mul_a = {{(MUL_W-DLO_W){1'b0}}, r_d1[DLO_W-1:0]};
                        mul_b = {{(MUL_W-DM_W){r_e1[DM_W-1]}}, r_e1};
                    end
                    3'd2: begin
                        mul_a = {{(MUL_W-DB_W+DLO_W){r_d2[DB_W-1]}}, r_d2[DB_W-1:DLO_W]};
                        mul_b = {{(MUL_W-DM_W){r_e2[DM_W-1]}}, r_e2};
                    end
                    3'd3: begin
                        mul_a = {{(MUL_W-DLO_W){1'b0}}, r_d2[DLO_W-1:0]};
                        mul_b = {{(MUL_W-DM_W){r_e2[DM_W-1]}}, r_e2};
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_QRD0, S_QRD1, S_QF1: begin
                mul_a = {{(MUL_W-SLOPE_W){ram_line.m[SLOPE_W-1]}}, ram_line.m};
                mul_b = {{(MUL_W-POINT_W){r_x[POINT_W-1]}}, r_x};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        case (r_state)
            S_ISRCH:  ram_raddr = mid[AW-1:0];
            S_NB_P:   ram_raddr = AW'(r_l - 1'b1);
            S_NB_N:   ram_raddr = r_r[AW-1:0];
            S_RGT:    ram_raddr = AW'(r_r + 1'b1);
            S_LFT:    ram_raddr = AW'(r_l - 2'd2);
            S_CPY_RD: ram_raddr = r_up ? r_k[AW-1:0] : AW'(r_k - 1'b1);
            S_QSRCH:  ram_raddr = (r_lo < r_hi) ? mid[AW-1:0] : r_lo[AW-1:0];
            S_QRD0:   ram_raddr = AW'(r_mid + 1'b1);
            default:  ram_raddr = '0;
        endcase
        case (r_state)
            S_CPY_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_up ? AW'(r_k - r_gap) : r_k[AW-1:0];
                ram_wdata = ram_rdata;
            end
            S_WNEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_l[AW-1:0];
                ram_wdata = r_new;
            end
            default: begin
                ram_we    = 1'b0;
                ram_waddr = '0;
                ram_wdata = ram_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // in S_DONE the output register is handled by the state itself
            if (r_ovalid && o_rsp.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_val  <= '0;
                        r_stat <= ST_OK;
                        r_new  <= '{m: i_req.slope, b: i_req.intercept};
                        r_x    <= i_req.point;
                        r_lo   <= '0;
                        if (i_req.func == FUNC_INSERT) begin
                            r_hi <= r_cnt;
                            if (r_cnt == CW'(CAPACITY)) begin
                                r_stat  <= ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_ISRCH;
                            end
                        end else begin
                            r_hi <= r_cnt - 1'b1;
                            if (r_cnt == '0) begin
                                r_stat  <= ST_EMPTY;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_QSRCH;
                            end
                        end
                    end
                end
                // first stored slope above the new one
                S_ISRCH: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= mid;
                        r_state <= S_ISRCH_W;
                    end else begin
                        r_l     <= r_lo;
                        r_r     <= r_lo;
                        r_state <= S_NB_P;
                    end
                end
                S_ISRCH_W: begin
                    if (ram_line.m <= r_new.m) begin
                        r_lo <= r_mid + 1'b1;
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_ISRCH;
                end
                S_NB_P: begin
                    r_state <= (r_l != '0) ? S_NB_PW : S_NB_N;
                end
                S_NB_PW: begin
                    r_p1    <= ram_line;
                    r_state <= S_NB_N;
                end
                S_NB_N: begin
                    r_state <= (r_r < r_cnt) ? S_NB_NW : S_TNEW;
                end
                S_NB_NW: begin
                    r_n1    <= ram_line;
                    r_state <= S_TNEW;
                end
                S_TNEW: begin
                    if (r_l == '0) begin
                        r_state <= S_RGT;
                    end else if (r_r == r_cnt) begin
                        // new line is last: only an equal slope can hide it
                        if (r_p1.m == r_new.m && r_new.b <= r_p1.b) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RGT;
                        end
                    end else begin
                        r_d1    <= t_d1;
                        r_e1    <= t_e1;
                        r_d2    <= t_d2;
                        r_e2    <= t_e2;
                        r_acc   <= '0;
                        r_step  <= '0;
                        r_tsel  <= T_NEW;
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    r_acc  <= acc_sum;
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd4) begin
                        case (r_tsel)
                            T_NEW: begin
                                r_state <= red ? S_DONE : S_RGT;
                            end
                            T_RGT: begin
                                if (red) begin
                                    r_n1    <= r_n2;
                                    r_r     <= r_r + 1'b1;
                                    r_state <= S_RGT;
                                end else begin
                                    r_state <= S_LFT;
                                end
                            end
                            T_LFT: begin
                                if (red) begin
                                    r_p1    <= r_p2;
                                    r_l     <= r_l - 1'b1;
                                    r_state <= S_LFT;
                                end else begin
                                    r_state <= S_CSET;
                                end
                            end
                            default: r_state <= S_CSET;
                        endcase
                    end
                end
                S_RGT: begin
                    r_state <= ({1'b0, r_r} + 1'b1 < {1'b0, r_cnt}) ? S_RGT_W : S_LFT;
                end
                S_RGT_W: begin
                    r_n2    <= ram_line;
                    r_d1    <= t_d1;
                    r_e1    <= t_e1;
                    r_d2    <= t_d2;
                    r_e2    <= t_e2;
                    r_acc   <= '0;
                    r_step  <= '0;
                    r_tsel  <= T_RGT;
                    r_state <= S_TEST;
                end
                S_LFT: begin
                    if (r_l == '0) begin
                        r_state <= S_CSET;
                    end else if (r_l == CW'(1)) begin
                        // leftmost line against the new one: equal slopes only
                        if (r_p1.m == r_new.m && r_p1.b <= r_new.b) begin
                            r_l <= '0;
                        end
                        r_state <= S_CSET;
                    end else begin
                        r_state <= S_LFT_W;
                    end
                end
                S_LFT_W: begin
                    r_p2    <= ram_line;
                    r_d1    <= t_d1;
                    r_e1    <= t_e1;
                    r_d2    <= t_d2;
                    r_e2    <= t_e2;
                    r_acc   <= '0;
                    r_step  <= '0;
                    r_tsel  <= T_LFT;
                    r_state <= S_TEST;
                end
                // move the kept tail next to the new line's slot
                S_CSET: begin
                    if (r_l == r_r) begin
                        r_up <= 1'b0;
                        r_k  <= r_cnt;
                    end else begin
                        r_up  <= 1'b1;
                        r_k   <= r_r;
                        r_gap <= r_r - r_l - 1'b1;
                    end
                    r_state <= S_CPY_RD;
                end
                S_CPY_RD: begin
                    if (r_up) begin
                        r_state <= (r_k < r_cnt) ? S_CPY_WR : S_WNEW;
                    end else begin
                        r_state <= (r_k > r_r) ? S_CPY_WR : S_WNEW;
                    end
                end
                S_CPY_WR: begin
                    r_k     <= r_up ? r_k + 1'b1 : r_k - 1'b1;
                    r_state <= S_CPY_RD;
                end
                S_WNEW: begin
                    r_cnt   <= new_cnt[CW-1:0];
                    r_state <= S_DONE;
                end
                S_QSRCH: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= mid;
                        r_state <= S_QRD0;
                    end else begin
                        r_state <= S_QF1;
                    end
                end
                S_QRD0: begin
                    r_vb    <= ram_line.b;
                    r_state <= S_QRD1;
                end
                S_QRD1: begin
                    r_v0    <= qval;
                    r_vb    <= ram_line.b;
                    r_state <= S_QM2;
                end
                S_QM2: begin
                    if ($signed(r_v0) < $signed(qval)) begin
                        r_lo <= r_mid + 1'b1;
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_QSRCH;
                end
                S_QF1: begin
                    r_vb    <= ram_line.b;
                    r_state <= S_QF2;
                end
                S_QF2: begin
                    r_val   <= qval;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ovalue  <= r_val;
                        r_ostatus <= r_stat;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/dchq_checker.sv
// port level checks of the hull block and their binding to the top level
module dchq_checker import dchq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [VALUE_W-1:0]  i_value,
    input logic [STATUS_W-1:0] i_status
);
    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_value) && $stable(i_status))
        else $error("response changed while stalled");

    // error responses carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ST_OK |-> i_value == '0)
        else $error("error response with nonzero value");

    // reset drops any pending response
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // a response never appears in the cycle right after a request transfer
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !$rose(i_rsp_valid))
        else $error("response too early");
endmodule

bind dynamic_convex_hull_max_query_top dchq_checker u_dchq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_value     (o_rsp.value),
    .i_status    (o_rsp.status)
);
